>>> src/rbs_pkg.sv
// ----------------------------------------------------------------------------
// rbs_pkg
// Shared types and constants for the record sort-by-key block: the record
// layout, the sequencer states and the control group to the datapath.
// ----------------------------------------------------------------------------
package rbs_pkg;

    // Default store depth
    localparam int MAX_RECORDS_DEF = 32;

    // Field and record widths
    localparam int WORD_W = 32;
    localparam int REC_W  = 4 * WORD_W;

    // One stored record, key in the low word
    typedef struct packed {
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] kind;
        logic [WORD_W-1:0] key;
    } t_rec;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PRIME,
        ST_FIRST,
        ST_PASS,
        ST_TAIL,
        ST_E_READ,
        ST_E_LOAD,
        ST_E_HOLD
    } t_state;

    // Source of the store write data
    typedef enum logic [1:0] {
        WSEL_INPUT,
        WSEL_LOWER,
        WSEL_CARRY
    } t_wsel;

    // Control group from sequencer to datapath
    typedef struct packed {
        logic  carry_ld;
        logic  pass_cmp;
        logic  out_ld;
        t_wsel wsel;
        logic  last_flag;
        logic  drop_flag;
    } t_dp_ctl;

endpackage

>>> src/rbs_ram.sv
// ----------------------------------------------------------------------------
// rbs_ram
// Generic simple dual-port RAM: one write port, one read port with the
// read data registered.
// ----------------------------------------------------------------------------
module rbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/rbs_swap.sv
// ----------------------------------------------------------------------------
// rbs_swap
// Bubble-pass datapath: holds the record being carried up through the
// store, compares it with the record just read and picks which one is
// written back below.
// ----------------------------------------------------------------------------
module rbs_swap (
    input  logic             i_clk,
    input  rbs_pkg::t_dp_ctl i_ctl,
    input  rbs_pkg::t_rec    i_rd_rec,
    output logic             o_swap,
    output rbs_pkg::t_rec    o_lower,
    output rbs_pkg::t_rec    o_carry
);

    rbs_pkg::t_rec r_carry;
    logic          greater;

    // Strictly greater only, so equal keys keep their order
    assign greater = r_carry.key > i_rd_rec.key;
    assign o_swap  = i_ctl.pass_cmp & greater;
    assign o_lower = greater ? i_rd_rec : r_carry;
    assign o_carry = r_carry;

    // Load the first record of a pass, then keep the larger of each pair
    always_ff @(posedge i_clk) begin
        if (i_ctl.carry_ld) begin
            r_carry <= i_rd_rec;
        end else if (i_ctl.pass_cmp && !greater) begin
            r_carry <= i_rd_rec;
        end
    end

endmodule

>>> src/rbs_ctrl.sv
// ----------------------------------------------------------------------------
// rbs_ctrl
// Sequencer: loads records into the store, runs bubble passes until one
// makes no swap, then reads the records out in order.
// ----------------------------------------------------------------------------
module rbs_ctrl #(
    parameter int MAX_RECORDS = rbs_pkg::MAX_RECORDS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_last_in,
    output logic                           o_in_ready,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    input  logic                           i_swap,
    output rbs_pkg::t_dp_ctl               o_ctl,
    output logic                           o_ram_we,
    output logic [$clog2(MAX_RECORDS)-1:0] o_ram_waddr,
    output logic [$clog2(MAX_RECORDS)-1:0] o_ram_raddr
);

    localparam int AW = $clog2(MAX_RECORDS);
    localparam int CW = $clog2(MAX_RECORDS + 1);
    localparam logic [CW-1:0] MaxCount = CW'(MAX_RECORDS);
    localparam logic [CW-1:0] One      = CW'(1);

    rbs_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_idx, n_idx;
    logic            r_dropped, n_dropped;
    logic            r_swapped, n_swapped;

    logic            in_acc;
    logic            room;
    logic            at_last;
    logic [CW-1:0]   last_idx;
    logic [CW-1:0]   idx_next;
    logic [CW-1:0]   idx_prev;

    assign o_in_ready  = (r_state == rbs_pkg::ST_LOAD);
    assign o_out_valid = (r_state == rbs_pkg::ST_E_HOLD);
    assign in_acc      = i_in_valid & o_in_ready;
    assign room        = (r_count != MaxCount);
    assign last_idx    = r_count - One;
    assign at_last     = (r_idx == last_idx);
    assign idx_next    = r_idx + One;
    assign idx_prev    = r_idx - One;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rbs_pkg::ST_LOAD: begin
                if (in_acc && i_last_in) begin
                    // Two or more records held after this item: sort them
                    n_state = (r_count != '0) ? rbs_pkg::ST_PRIME : rbs_pkg::ST_E_READ;
                end
            end
            rbs_pkg::ST_PRIME: n_state = rbs_pkg::ST_FIRST;
            rbs_pkg::ST_FIRST: n_state = rbs_pkg::ST_PASS;
            rbs_pkg::ST_PASS: begin
                if (at_last) begin
                    n_state = rbs_pkg::ST_TAIL;
                end
            end
            rbs_pkg::ST_TAIL: begin
                n_state = r_swapped ? rbs_pkg::ST_PRIME : rbs_pkg::ST_E_READ;
            end
            rbs_pkg::ST_E_READ: n_state = rbs_pkg::ST_E_LOAD;
            rbs_pkg::ST_E_LOAD: n_state = rbs_pkg::ST_E_HOLD;
            rbs_pkg::ST_E_HOLD: begin
                if (i_out_ready) begin
                    n_state = at_last ? rbs_pkg::ST_LOAD : rbs_pkg::ST_E_READ;
                end
            end
            default: n_state = rbs_pkg::ST_LOAD;
        endcase
    end

    // Outputs: store access and datapath control
    always_comb begin
        o_ctl          = '0;
        o_ctl.wsel     = rbs_pkg::WSEL_INPUT;
        o_ram_we       = 1'b0;
        o_ram_waddr    = r_count[AW-1:0];
        o_ram_raddr    = r_idx[AW-1:0];
        unique case (r_state)
            rbs_pkg::ST_LOAD: begin
                o_ram_we = in_acc & room;
            end
            rbs_pkg::ST_PRIME: begin
                o_ram_raddr = '0;
            end
            rbs_pkg::ST_FIRST: begin
                o_ctl.carry_ld = 1'b1;
                o_ram_raddr    = AW'(1);
            end
            rbs_pkg::ST_PASS: begin
                o_ctl.pass_cmp = 1'b1;
                o_ctl.wsel     = rbs_pkg::WSEL_LOWER;
                o_ram_we       = 1'b1;
                o_ram_waddr    = idx_prev[AW-1:0];
                o_ram_raddr    = idx_next[AW-1:0];
            end
            rbs_pkg::ST_TAIL: begin
                o_ctl.wsel  = rbs_pkg::WSEL_CARRY;
                o_ram_we    = 1'b1;
                o_ram_waddr = last_idx[AW-1:0];
            end
            rbs_pkg::ST_E_READ: begin
                o_ram_raddr = r_idx[AW-1:0];
            end
            rbs_pkg::ST_E_LOAD: begin
                o_ctl.out_ld    = 1'b1;
                o_ctl.last_flag = at_last;
                o_ctl.drop_flag = r_dropped;
            end
            rbs_pkg::ST_E_HOLD: begin
                o_ram_raddr = r_idx[AW-1:0];
            end
            default: begin
                o_ram_we = 1'b0;
            end
        endcase
    end

    // Counters and flags
    always_comb begin
        n_count   = r_count;
        n_idx     = r_idx;
        n_dropped = r_dropped;
        n_swapped = r_swapped;
        case (r_state)
            rbs_pkg::ST_LOAD: begin
                if (in_acc) begin
                    if (room) begin
                        n_count = r_count + One;
                    end else begin
                        n_dropped = 1'b1;
                    end
                end
                n_idx = '0;
            end
            rbs_pkg::ST_PRIME: begin
                n_swapped = 1'b0;
                n_idx     = '0;
            end
            rbs_pkg::ST_FIRST: n_idx = One;
            rbs_pkg::ST_PASS: begin
                n_swapped = r_swapped | i_swap;
                n_idx     = idx_next;
            end
            rbs_pkg::ST_TAIL: n_idx = '0;
            rbs_pkg::ST_E_HOLD: begin
                if (i_out_ready) begin
                    n_idx = idx_next;
                    if (at_last) begin
                        n_count   = '0;
                        n_dropped = 1'b0;
                    end
                end
            end
            default: n_idx = r_idx;
        endcase
    end

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rbs_pkg::ST_LOAD;
            r_count   <= '0;
            r_idx     <= '0;
            r_dropped <= 1'b0;
            r_swapped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_dropped <= n_dropped;
            r_swapped <= n_swapped;
        end
    end

    // Checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MaxCount)
        else $error("record count beyond capacity");

    a_pass_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rbs_pkg::ST_PASS) |-> (o_ram_waddr != o_ram_raddr))
        else $error("pass writes and reads the same entry");

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("load and emit overlap");

    a_clean_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rbs_pkg::ST_TAIL && !r_swapped) |=> (r_state == rbs_pkg::ST_E_READ))
        else $error("sort did not stop after a clean pass");

    a_set_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && at_last) |=> (r_count == '0 && !r_dropped))
        else $error("set not cleared after final item");

endmodule

>>> src/record_bubble_sort_by_key_core.sv
// ----------------------------------------------------------------------------
// record_bubble_sort_by_key_core
// Loads a set of records, sorts them ascending by unsigned key with a stable
// early-exit bubble sort held in one RAM, and streams them out in order.
//
//   Channel  Dir  Handshake                  Payload
//   in       in   i_in_valid / o_in_ready    pos_x, pos_y, item_kind, sort_key, last_in
//   out      out  o_out_valid / i_out_ready  out_x, out_y, out_kind, out_key, last_out, overflow
//
// Loading accepts one item per cycle. Sorting n records (n >= 2) takes p
// passes, p <= n, each pass streaming through the single read port and
// single write port of the record RAM. Each record is emitted through the
// read, load and hold states; the hold lasts through any stall on the out
// channel. No input is taken from the last item of a set until its final
// result is delivered. Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module record_bubble_sort_by_key_core #(
    parameter int MAX_RECORDS = rbs_pkg::MAX_RECORDS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_item_kind,
    input  logic        [31:0] i_sort_key,
    input  logic               i_last_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_kind,
    output logic        [31:0] o_out_key,
    output logic               o_last_out,
    output logic               o_overflow
);

    localparam int AW = $clog2(MAX_RECORDS);

    rbs_pkg::t_dp_ctl          ctl;
    logic                      swap;
    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [AW-1:0]             ram_raddr;
    logic [rbs_pkg::REC_W-1:0] ram_rdata;
    rbs_pkg::t_rec             rd_rec;
    rbs_pkg::t_rec             in_rec;
    rbs_pkg::t_rec             lower_rec;
    rbs_pkg::t_rec             carry_rec;
    rbs_pkg::t_rec             wr_rec;

    rbs_pkg::t_rec             r_out;
    logic                      r_last;
    logic                      r_ovf;

    assign rd_rec = rbs_pkg::t_rec'(ram_rdata);

    // Pack the incoming item
    always_comb begin
        in_rec.x    = i_pos_x;
        in_rec.y    = i_pos_y;
        in_rec.kind = i_item_kind;
        in_rec.key  = i_sort_key;
    end

    // Select the store write data
    always_comb begin
        unique case (ctl.wsel)
            rbs_pkg::WSEL_INPUT: wr_rec = in_rec;
            rbs_pkg::WSEL_LOWER: wr_rec = lower_rec;
            rbs_pkg::WSEL_CARRY: wr_rec = carry_rec;
            default:             wr_rec = in_rec;
        endcase
    end

    rbs_ctrl #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_in   (i_last_in),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_swap      (swap),
        .o_ctl       (ctl),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_raddr (ram_raddr)
    );

    rbs_ram #(
        .WIDTH (rbs_pkg::REC_W),
        .DEPTH (MAX_RECORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wr_rec),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    rbs_swap u_swap (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_rd_rec (rd_rec),
        .o_swap   (swap),
        .o_lower  (lower_rec),
        .o_carry  (carry_rec)
    );

    // Hold the outgoing item
    always_ff @(posedge i_clk) begin
        if (ctl.out_ld) begin
            r_out  <= rd_rec;
            r_last <= ctl.last_flag;
            r_ovf  <= ctl.drop_flag;
        end
    end

    assign o_out_x    = r_out.x;
    assign o_out_y    = r_out.y;
    assign o_out_kind = r_out.kind;
    assign o_out_key  = r_out.key;
    assign o_last_out = r_last;
    assign o_overflow = r_ovf;

endmodule
